FILE: hdl/bltb_pkg.sv
// Shared types, register codes and constants for the bilinear texel blend unit.
package bltb_pkg;

   localparam int TexelCount = 4;

   localparam logic [16:0] ONE_Q16          = 17'h10000;
   localparam logic [16:0] BLEND_MIN_FACTOR = 17'd256;
   localparam logic [7:0]  OPAQUE_ALPHA     = 8'hFF;

   localparam logic [1:0] MODE_COLOUR = 2'd0;
   localparam logic [1:0] MODE_GREY   = 2'd1;
   localparam logic [1:0] MODE_BLEND  = 2'd2;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 9;

   localparam logic [CsrIndexWidth-1:0] REG_MODE    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] REG_OPACITY = 2'd1;

   localparam logic [1:0] MODE_RESET    = MODE_COLOUR;
   localparam logic [8:0] OPACITY_RESET = 9'd256;

   typedef struct packed {
      logic [TexelCount-1:0][31:0] texel;
      logic [15:0]                 frac_x;
      logic [15:0]                 frac_y;
      logic [31:0]                 dest;
   } sample_type;

   typedef struct packed {
      logic [TexelCount-1:0][31:0] texel;
      logic [TexelCount-1:0][16:0] weight;
      logic [31:0]                 dest;
   } weighted_type;

   typedef struct packed {
      logic [23:0] alpha_acc;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [31:0] dest;
   } filtered_type;

   typedef struct packed {
      logic [16:0] factor;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [31:0] dest;
   } factored_type;

   typedef struct packed {
      logic [31:0] pixel;
      logic        written;
   } result_type;

endpackage

FILE: hdl/bltb_weights.sv
// Stage one: bilinear weights from the x and y fractions.
module bltb_weights
   import bltb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  sample_type   in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output weighted_type out_data
);

   logic         valid_ff;
   logic         valid_in;
   weighted_type data_ff;
   weighted_type data_in;
   logic [16:0]  frac_x_ext;
   logic [16:0]  frac_y_ext;
   logic [16:0]  comp_x;
   logic [16:0]  comp_y;
   logic [33:0]  prod_tl;
   logic [33:0]  prod_tr;
   logic [33:0]  prod_bl;
   logic [33:0]  prod_br;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      frac_x_ext = {1'b0, in_data.frac_x};
      frac_y_ext = {1'b0, in_data.frac_y};
      comp_x     = ONE_Q16 - frac_x_ext;
      comp_y     = ONE_Q16 - frac_y_ext;
      prod_tl    = 34'(comp_x) * 34'(comp_y);
      prod_tr    = 34'(frac_x_ext) * 34'(comp_y);
      prod_bl    = 34'(comp_x) * 34'(frac_y_ext);
      prod_br    = 34'(frac_x_ext) * 34'(frac_y_ext);
      data_in.texel     = in_data.texel;
      data_in.weight[0] = prod_tl[32:16];
      data_in.weight[1] = prod_tr[32:16];
      data_in.weight[2] = prod_bl[32:16];
      data_in.weight[3] = prod_br[32:16];
      data_in.dest      = in_data.dest;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/bltb_filter.sv
// Stage two: weighted sums of the four texels for each ARGB channel.
module bltb_filter
   import bltb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  weighted_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output filtered_type out_data
);

   logic               valid_ff;
   logic               valid_in;
   filtered_type       data_ff;
   filtered_type       data_in;
   logic [3:0][26:0]   chan_sum;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         chan_sum[c] = '0;
         for (int t = 0; t < TexelCount; t++) begin
            chan_sum[c] = chan_sum[c]
                        + 27'(27'(in_data.texel[t][c*8 +: 8]) * 27'(in_data.weight[t]));
         end
      end
      data_in.alpha_acc = chan_sum[3][23:0];
      data_in.red       = chan_sum[2][23:16];
      data_in.green     = chan_sum[1][23:16];
      data_in.blue      = chan_sum[0][23:16];
      data_in.dest      = in_data.dest;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/bltb_factor.sv
// Stage three: blend factor from filtered alpha and global opacity.
module bltb_factor
   import bltb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [8:0]   opacity,
   input  logic         in_valid,
   output logic         in_ready,
   input  filtered_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output factored_type out_data
);

   logic         valid_ff;
   logic         valid_in;
   factored_type data_ff;
   factored_type data_in;
   logic [32:0]  scaled;
   logic [16:0]  factor_raw;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      scaled     = 33'(in_data.alpha_acc) * 33'(opacity);
      factor_raw = scaled[32:16];
      data_in.factor = (factor_raw > ONE_Q16) ? ONE_Q16 : factor_raw;
      data_in.red    = in_data.red;
      data_in.green  = in_data.green;
      data_in.blue   = in_data.blue;
      data_in.dest   = in_data.dest;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/bltb_blend.sv
// Stage four: destination blend and mode selection into the output register.
module bltb_blend
   import bltb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   mode,
   input  logic         in_valid,
   output logic         in_ready,
   input  factored_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output result_type   out_data
);

   logic             valid_ff;
   logic             valid_in;
   result_type       data_ff;
   result_type       data_in;
   logic [16:0]      inv_factor;
   logic [2:0][7:0]  src_chan;
   logic [2:0][25:0] mix;
   logic [2:0][7:0]  mixed;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      inv_factor  = ONE_Q16 - in_data.factor;
      src_chan[2] = in_data.red;
      src_chan[1] = in_data.green;
      src_chan[0] = in_data.blue;
      for (int c = 0; c < 3; c++) begin
         mix[c] = 26'(26'(in_data.dest[c*8 +: 8]) * 26'(inv_factor))
                + 26'(26'(src_chan[c]) * 26'(in_data.factor));
         mixed[c] = mix[c][23:16];
      end
      data_in.pixel   = in_data.dest;
      data_in.written = 1'b0;
      unique case (mode)
         MODE_COLOUR: begin
            data_in.pixel   = {OPAQUE_ALPHA, in_data.red, in_data.green, in_data.blue};
            data_in.written = 1'b1;
         end
         MODE_GREY: begin
            data_in.pixel   = {OPAQUE_ALPHA, in_data.blue, in_data.blue, in_data.blue};
            data_in.written = 1'b1;
         end
         MODE_BLEND: begin
            if (in_data.factor > BLEND_MIN_FACTOR) begin
               data_in.pixel   = {OPAQUE_ALPHA, mixed[2], mixed[1], mixed[0]};
               data_in.written = 1'b1;
            end
         end
         default: begin
            data_in.pixel   = in_data.dest;
            data_in.written = 1'b0;
         end
      endcase
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/bilinear_texel_blend_unit.sv
// Bilinear texel filter with alpha blend: top level, register file and pipeline.
// Pipeline: weights, channel filter, blend factor, blend and select, each a registered
// stage; a request passes through them in that order before rsp_valid rises, and a
// stall can hold it in any stage.
// Throughput: one pixel per cycle while rsp_stall is low; a full stage holds while its successor is not ready.
// Reset: synchronous, clears all stage valid bits, mode to 0 and opacity to 256.
module bilinear_texel_blend_unit
   import bltb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [31:0]              req_texel_top_left,
   input  logic [31:0]              req_texel_top_right,
   input  logic [31:0]              req_texel_bottom_left,
   input  logic [31:0]              req_texel_bottom_right,
   input  logic [15:0]              req_frac_x,
   input  logic [15:0]              req_frac_y,
   input  logic [31:0]              req_dest_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [31:0]              rsp_pixel_out,
   output logic                     rsp_written,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   logic [1:0]   mode_ff;
   logic [1:0]   mode_in;
   logic [8:0]   opacity_ff;
   logic [8:0]   opacity_in;

   sample_type   sample;
   logic         s1_ready;
   logic         s1_valid;
   weighted_type s1_data;
   logic         s2_ready;
   logic         s2_valid;
   filtered_type s2_data;
   logic         s3_ready;
   logic         s3_valid;
   factored_type s3_data;
   logic         s4_ready;
   result_type   s4_data;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in    = mode_ff;
      opacity_in = opacity_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODE:    mode_in    = csr_data[1:0];
            REG_OPACITY: opacity_in = csr_data[8:0];
            default: begin
               mode_in    = mode_ff;
               opacity_in = opacity_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RESET;
         opacity_ff <= OPACITY_RESET;
      end else begin
         mode_ff    <= mode_in;
         opacity_ff <= opacity_in;
      end
   end

   always_comb begin
      sample.texel[0] = req_texel_top_left;
      sample.texel[1] = req_texel_top_right;
      sample.texel[2] = req_texel_bottom_left;
      sample.texel[3] = req_texel_bottom_right;
      sample.frac_x   = req_frac_x;
      sample.frac_y   = req_frac_y;
      sample.dest     = req_dest_pixel;
   end

   assign req_stall = !s1_ready;

   bltb_weights u_weights (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (s1_ready),
      .in_data   (sample),
      .out_valid (s1_valid),
      .out_ready (s2_ready),
      .out_data  (s1_data)
   );

   bltb_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s2_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s3_ready),
      .out_data  (s2_data)
   );

   bltb_factor u_factor (
      .clock     (clock),
      .reset     (reset),
      .opacity   (opacity_ff),
      .in_valid  (s2_valid),
      .in_ready  (s3_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s4_ready),
      .out_data  (s3_data)
   );

   bltb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (s3_valid),
      .in_ready  (s4_ready),
      .in_data   (s3_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (s4_data)
   );

   assign rsp_pixel_out = s4_data.pixel;
   assign rsp_written   = s4_data.written;

   a_written_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_written |-> rsp_pixel_out[31:24] == OPAQUE_ALPHA)
      else $error("written pixel without opaque alpha");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid && s2_valid && s3_valid && rsp_valid && rsp_stall)
      else $error("input stalled while the pipeline has a free stage");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_valid && !s2_valid && !s3_valid)
      else $error("pipeline holds a valid item after reset");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the bilinear texel blend unit.
`timescale 1ns / 100ps

module tb_top
   import bltb_pkg::*;
();

   localparam int PipeLatency   = 4;
   localparam int WatchdogLimit = 2000;
   localparam int HoldCycles    = 120;
   localparam int HoldAfter     = 300;
   localparam int RandomPhases  = 8;
   localparam int PhaseItems    = 128;
   localparam int NumDirected   = 20;

   localparam logic [1:0] MODE_IGNORED = 2'd3;

   typedef struct packed {
      logic [31:0] top_left;
      logic [31:0] top_right;
      logic [31:0] bottom_left;
      logic [31:0] bottom_right;
      logic [15:0] frac_x;
      logic [15:0] frac_y;
      logic [31:0] dest;
   } pixel_sample_type;

   typedef struct packed {
      logic [31:0] pixel;
      logic        written;
   } pixel_result_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [8:0]       opacity;
      pixel_sample_type sample;
      logic             typed;
      pixel_result_type want;
   } directed_row_type;

   typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_SPARSE} stall_style_type;

   localparam logic [31:0] TX_A = 32'h11223344;
   localparam logic [31:0] TX_B = 32'h55667788;
   localparam logic [31:0] TX_C = 32'h99AABBCC;
   localparam logic [31:0] TX_D = 32'hDDEEFF00;

   directed_row_type directed_rows [NumDirected] = '{
      '{MODE_COLOUR, 9'd256, '{32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h12345678},
        1'b1, '{32'hFF000000, 1'b1}},
      '{MODE_COLOUR, 9'd256, '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        16'h0, 16'h0, 32'h0}, 1'b1, '{32'hFFFFFFFF, 1'b1}},
      '{MODE_COLOUR, 9'd256, '{TX_A, TX_B, TX_C, TX_D, 16'hFFFF, 16'hFFFF, 32'h0},
        1'b0, '{32'h0, 1'b0}},
      '{MODE_COLOUR, 9'd256, '{TX_A, TX_B, TX_C, TX_D, 16'h0, 16'hFFFF, 32'hFFFFFFFF},
        1'b0, '{32'h0, 1'b0}},
      '{MODE_COLOUR, 9'd256, '{TX_A, TX_B, TX_C, TX_D, 16'hFFFF, 16'h0, 32'h0},
        1'b0, '{32'h0, 1'b0}},
      '{MODE_COLOUR, 9'd256, '{TX_A, TX_B, TX_C, TX_D, 16'h8000, 16'h8000, 32'h0},
        1'b0, '{32'h0, 1'b0}},
      '{MODE_COLOUR, 9'd256, '{32'h00A1B2C3, TX_B, TX_C, TX_D, 16'h0, 16'h0, 32'h0},
        1'b1, '{32'hFFA1B2C3, 1'b1}},
      '{MODE_GREY, 9'd256, '{32'h123456AB, TX_B, TX_C, TX_D, 16'h0, 16'h0, 32'h0},
        1'b1, '{32'hFFABABAB, 1'b1}},
      '{MODE_GREY, 9'd256, '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        16'h1234, 16'hABCD, 32'h0}, 1'b0, '{32'h0, 1'b0}},
      '{MODE_GREY, 9'd256, '{TX_A, TX_B, TX_C, TX_D, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF},
        1'b0, '{32'h0, 1'b0}},
      '{MODE_BLEND, 9'd256, '{32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF,
        16'h7777, 16'h3333, 32'hCAFEBABE}, 1'b1, '{32'hCAFEBABE, 1'b0}},
      '{MODE_BLEND, 9'd256, '{32'h01FFFFFF, TX_B, TX_C, TX_D, 16'h0, 16'h0, 32'h0},
        1'b1, '{32'h0, 1'b0}},
      '{MODE_BLEND, 9'd256, '{32'h02FFFFFF, TX_B, TX_C, TX_D, 16'h0, 16'h0, 32'h0},
        1'b0, '{32'h0, 1'b0}},
      '{MODE_BLEND, 9'd256, '{32'h80102030, 32'h80405060, 32'h80708090, 32'h80A0B0C0,
        16'h8000, 16'h8000, 32'hFFFFFFFF}, 1'b0, '{32'h0, 1'b0}},
      '{MODE_BLEND, 9'd0, '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        16'h4000, 16'hC000, 32'h87654321}, 1'b1, '{32'h87654321, 1'b0}},
      '{MODE_BLEND, 9'd511, '{32'hFF445566, TX_B, TX_C, TX_D, 16'h0, 16'h0, 32'h0},
        1'b1, '{32'hFF445566, 1'b1}},
      '{MODE_BLEND, 9'd511, '{32'hFF123456, 32'hFF789ABC, 32'hFFDEF012, 32'hFF345678,
        16'h4000, 16'hC000, 32'hFFFFFFFF}, 1'b0, '{32'h0, 1'b0}},
      '{MODE_BLEND, 9'd257, '{32'h01FFFFFF, TX_B, TX_C, TX_D, 16'h0, 16'h0, 32'hFFFFFFFF},
        1'b0, '{32'h0, 1'b0}},
      '{MODE_IGNORED, 9'd256, '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        16'h8000, 16'h8000, 32'h5A5AA5A5}, 1'b1, '{32'h5A5AA5A5, 1'b0}},
      '{MODE_IGNORED, 9'd511, '{TX_A, TX_B, TX_C, TX_D, 16'hFFFF, 16'h0, 32'hFFFFFFFF},
        1'b1, '{32'hFFFFFFFF, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [31:0] req_texel_top_left;
   logic [31:0] req_texel_top_right;
   logic [31:0] req_texel_bottom_left;
   logic [31:0] req_texel_bottom_right;
   logic [15:0] req_frac_x;
   logic [15:0] req_frac_y;
   logic [31:0] req_dest_pixel;
   logic rsp_valid;
   logic rsp_stall;
   logic [31:0] rsp_pixel_out;
   logic rsp_written;
   logic csr_valid;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_data;

   logic             offer_typed;
   pixel_result_type offer_want;

   logic [1:0]       mode_shadow;
   logic [8:0]       opacity_shadow;
   pixel_result_type expected_pixels [$];
   pixel_result_type want_pixel;
   pixel_sample_type seen_sample;
   int               error_count = 0;
   int               results_seen = 0;
   int               burst_left = 0;
   logic [1:0]       set_mode;
   logic [8:0]       set_opacity;

   bilinear_texel_blend_unit dut (.*);

   always #5ns clock = ~clock;

   function automatic pixel_result_type predict_texel_blend(pixel_sample_type s,
                                                            logic [1:0] m,
                                                            logic [8:0] op);
      logic [31:0]      tex [4];
      longint unsigned  wgt [4];
      longint unsigned  acc [4];
      longint unsigned  cx, cy, fx, fy, f;
      logic [7:0]       src [3];
      logic [7:0]       mix [3];
      pixel_result_type r;
      tex = '{s.top_left, s.top_right, s.bottom_left, s.bottom_right};
      fx = s.frac_x;
      fy = s.frac_y;
      cx = ONE_Q16 - fx;
      cy = ONE_Q16 - fy;
      wgt[0] = (cx * cy) >> 16;
      wgt[1] = (fx * cy) >> 16;
      wgt[2] = (cx * fy) >> 16;
      wgt[3] = (fx * fy) >> 16;
      for (int c = 0; c < 4; c++) begin
         acc[c] = 0;
         for (int i = 0; i < 4; i++) acc[c] += longint'(tex[i][8*c +: 8]) * wgt[i];
      end
      for (int c = 0; c < 3; c++) src[c] = 8'(acc[c] >> 16);
      r.pixel = s.dest;
      r.written = 1'b0;
      case (m)
         MODE_COLOUR: begin
            r.pixel = {OPAQUE_ALPHA, src[2], src[1], src[0]};
            r.written = 1'b1;
         end
         MODE_GREY: begin
            r.pixel = {OPAQUE_ALPHA, src[0], src[0], src[0]};
            r.written = 1'b1;
         end
         MODE_BLEND: begin
            f = (acc[3] * op) >> 16;
            if (f > ONE_Q16) f = ONE_Q16;
            if (f > BLEND_MIN_FACTOR) begin
               for (int c = 0; c < 3; c++)
                  mix[c] = 8'((longint'(s.dest[8*c +: 8]) * (ONE_Q16 - f)
                               + longint'(src[c]) * f) >> 16);
               r.pixel = {OPAQUE_ALPHA, mix[2], mix[1], mix[0]};
               r.written = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mode_shadow <= MODE_RESET;
         opacity_shadow <= OPACITY_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            seen_sample = '{req_texel_top_left, req_texel_top_right, req_texel_bottom_left,
                            req_texel_bottom_right, req_frac_x, req_frac_y, req_dest_pixel};
            if (offer_typed) expected_pixels.push_back(offer_want);
            else expected_pixels.push_back(predict_texel_blend(seen_sample, mode_shadow,
                                                               opacity_shadow));
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected transfer pixel_out %h written %b",
                        $time, rsp_pixel_out, rsp_written);
               error_count++;
            end else begin
               want_pixel = expected_pixels.pop_front();
               if (rsp_pixel_out !== want_pixel.pixel) begin
                  $display("%0t: pixel_out expected %h actual %h",
                           $time, want_pixel.pixel, rsp_pixel_out);
                  error_count++;
               end
               if (rsp_written !== want_pixel.written) begin
                  $display("%0t: written expected %b actual %b",
                           $time, want_pixel.written, rsp_written);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODE:    mode_shadow <= csr_data[1:0];
               REG_OPACITY: opacity_shadow <= csr_data;
               default: ;
            endcase
         end
      end
   end

   task automatic offer_sample(pixel_sample_type s, logic typed, pixel_result_type want);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_texel_top_left <= s.top_left;
      req_texel_top_right <= s.top_right;
      req_texel_bottom_left <= s.bottom_left;
      req_texel_bottom_right <= s.bottom_right;
      req_frac_x <= s.frac_x;
      req_frac_y <= s.frac_y;
      req_dest_pixel <= s.dest;
      offer_typed <= typed;
      offer_want <= want;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (PipeLatency + 2) @(negedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic reconfigure(logic [1:0] m, logic [8:0] op);
      drain_pipeline();
      write_reg(REG_MODE, CsrDataWidth'(m));
      write_reg(REG_OPACITY, op);
      @(negedge clock);
      csr_valid <= 1'b0;
      set_mode = m;
      set_opacity = op;
   endtask

   initial begin
      stall_style_type style;
      int seg_len;
      bit held;
      held = 1'b0;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         style = stall_style_type'($urandom_range(0, 3));
         seg_len = $urandom_range(10, 60);
         for (int k = 0; k < seg_len; k++) begin
            @(negedge clock);
            if (!held && results_seen >= HoldAfter) begin
               held = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HoldCycles) @(negedge clock);
            end
            case (style)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_COIN:     rsp_stall <= ($urandom_range(0, 1) == 0);
               STALL_PERIODIC: rsp_stall <= (k % 3 == 2);
               default:        rsp_stall <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WatchdogLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[bilinear_texel_blend_unit] ERROR");
      $finish;
   end

   initial begin
      pixel_sample_type s;
      logic [8:0]       op;
      logic [1:0]       m;
      reset = 1'b1;
      req_valid = 1'b0;
      req_texel_top_left = '0;
      req_texel_top_right = '0;
      req_texel_bottom_left = '0;
      req_texel_bottom_right = '0;
      req_frac_x = '0;
      req_frac_y = '0;
      req_dest_pixel = '0;
      csr_valid = 1'b0;
      csr_index = REG_MODE;
      csr_data = '0;
      offer_typed = 1'b0;
      offer_want = '0;
      set_mode = MODE_RESET;
      set_opacity = OPACITY_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].mode != set_mode || directed_rows[r].opacity != set_opacity)
            reconfigure(directed_rows[r].mode, directed_rows[r].opacity);
         offer_sample(directed_rows[r].sample, directed_rows[r].typed, directed_rows[r].want);
      end

      for (int p = 0; p < RandomPhases; p++) begin
         case (p % 4)
            0:       m = MODE_COLOUR;
            2:       m = MODE_GREY;
            default: m = MODE_BLEND;
         endcase
         case ($urandom_range(0, 4))
            0:       op = 9'd256;
            1:       op = 9'd511;
            2:       op = 9'd257;
            3:       op = 9'($urandom_range(1, 511));
            default: op = 9'($urandom_range(1, 32));
         endcase
         reconfigure(m, op);
         for (int n = 0; n < PhaseItems; n++) begin
            s.top_left = $urandom;
            s.top_right = $urandom;
            s.bottom_left = $urandom;
            s.bottom_right = $urandom;
            case ($urandom_range(0, 7))
               0:    s = '{s.top_left & 32'h00FFFFFF, s.top_right & 32'h00FFFFFF,
                           s.bottom_left & 32'h00FFFFFF, s.bottom_right & 32'h00FFFFFF,
                           16'h0, 16'h0, 32'h0};
               1, 2: s = '{s.top_left | 32'hFF000000, s.top_right | 32'hFF000000,
                           s.bottom_left | 32'hFF000000, s.bottom_right | 32'hFF000000,
                           16'h0, 16'h0, 32'h0};
               default: ;
            endcase
            case ($urandom_range(0, 7))
               0:       s.frac_x = 16'h0;
               1:       s.frac_x = 16'hFFFF;
               default: s.frac_x = 16'($urandom);
            endcase
            case ($urandom_range(0, 7))
               0:       s.frac_y = 16'h0;
               1:       s.frac_y = 16'hFFFF;
               default: s.frac_y = 16'($urandom);
            endcase
            case ($urandom_range(0, 9))
               0:       s.dest = 32'h0;
               1:       s.dest = 32'hFFFFFFFF;
               default: s.dest = $urandom;
            endcase
            offer_sample(s, 1'b0, '0);
         end
      end

      drain_pipeline();
      if (error_count == 0)
         $display("[bilinear_texel_blend_unit] OK");
      else
         $display("[bilinear_texel_blend_unit] ERROR");
      $finish;
   end

endmodule
